@@ design/shs_pkg.sv @@
package shs_pkg;

	localparam int WORD_W      = 32;
	localparam int BLK_WORDS   = 16;
	localparam int BLK_AW      = 4;
	localparam int CHAIN_WORDS = 8;
	localparam int CHAIN_AW    = 3;
	localparam int ROUNDS      = 64;
	localparam int LEN_POS     = 56;
	localparam int OUT_W       = 40;

	localparam logic [7:0] PAD_MARK = 8'h80;

	typedef logic [WORD_W-1:0] word_t;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_PAD    = 6'b000010,
		ST_LOAD   = 6'b000100,
		ST_ROUND  = 6'b001000,
		ST_UPDATE = 6'b010000,
		ST_OUT    = 6'b100000
	} state_t;

	localparam word_t ROUND_K [ROUNDS] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam word_t INIT_HASH [CHAIN_WORDS] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic word_t big_sigma0(input word_t x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic word_t big_sigma1(input word_t x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic word_t small_sigma0(input word_t x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic word_t small_sigma1(input word_t x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

	function automatic word_t choose(input word_t e, input word_t f, input word_t g);
		return (e & f) ^ (~e & g);
	endfunction

	function automatic word_t major(input word_t a, input word_t b, input word_t c);
		return (a & b) ^ (a & c) ^ (b & c);
	endfunction

endpackage

@@ design/shs_ram.sv @@
module shs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ design/sha256_stream_hasher.sv @@
// SHA-256 hasher for a byte stream. Each input beat carries one message byte; tuser marks
// the byte as part of the message and tlast ends the message (tuser low with tlast high
// ends it with the bytes already taken, or hashes the empty message). Bytes are taken one
// per cycle into a 16-word block memory; the 64th byte of a block stalls the input while
// the chaining words are read from their memory, 64 compression rounds run at one round
// per cycle, and the results are added and written back. On tlast the padding bytes are
// written through the same one-byte-per-cycle path, followed by the compressions, and the
// digest leaves as eight beats, word 0 first, each word read from the chaining memory
// before it is shown. Output beat tdata: bits 31:0 digest word, 34:32 word index; tlast
// flags word 7. The next message may start while the last digest beat still waits on the
// output.
module sha256_stream_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] data_byte
	input  logic        s_tuser,  // [0] byte_valid
	input  logic        s_tlast,  // final_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // [31:0] digest_word, [34:32] word_index, rest zero
	output logic        m_tlast   // last_word
);

	shs_pkg::state_t state_q;
	logic [5:0]  cnt_q;
	logic [5:0]  fill_q;
	logic [63:0] bits_q;
	logic [63:0] len_q;
	logic        final_q;
	logic        pad_q;
	logic        marker_q;
	logic        lenok_q;
	logic        fresh_q;
	logic        rdpend_s1;
	logic [shs_pkg::CHAIN_AW-1:0] caddr_s1;
	logic [23:0] wacc_q;
	shs_pkg::word_t vreg_q [shs_pkg::CHAIN_WORDS];
	shs_pkg::word_t win_q [shs_pkg::BLK_WORDS];
	logic        oval_q;
	shs_pkg::word_t oword_q;
	logic [2:0]  oidx_q;

	logic        accept;
	logic        byte_we;
	logic [7:0]  byte_val;
	logic [7:0]  pad_byte;
	logic        bwe;
	logic [shs_pkg::BLK_AW-1:0] braddr;
	shs_pkg::word_t brdata;
	logic [shs_pkg::CHAIN_AW-1:0] craddr;
	logic        cwe;
	shs_pkg::word_t crdata;
	shs_pkg::word_t chain_rd;
	shs_pkg::word_t cwdata;
	logic        issue;
	shs_pkg::word_t wt;
	shs_pkg::word_t t1;
	shs_pkg::word_t t2;

	assign s_tready = (state_q == shs_pkg::ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// Length bytes go out most significant first at block positions 56..63.
	always_comb begin
		if (!marker_q) begin
			pad_byte = shs_pkg::PAD_MARK;
		end else if (lenok_q && (fill_q >= 6'(shs_pkg::LEN_POS))) begin
			pad_byte = len_q[{~fill_q[2:0], 3'b000} +: 8];
		end else begin
			pad_byte = 8'h00;
		end
	end

	always_comb begin
		byte_we  = 1'b0;
		byte_val = s_tdata;
		if (state_q == shs_pkg::ST_IDLE) begin
			byte_we = accept && s_tuser;
		end else if (state_q == shs_pkg::ST_PAD) begin
			byte_we  = 1'b1;
			byte_val = pad_byte;
		end
	end

	assign bwe    = byte_we && (fill_q[1:0] == 2'b11);
	assign braddr = (state_q == shs_pkg::ST_ROUND) ? (cnt_q[3:0] + 4'd1) : '0;

	shs_ram #(
		.WIDTH(shs_pkg::WORD_W),
		.DEPTH(shs_pkg::BLK_WORDS)
	) u_block_ram (
		.clk  (clk),
		.we   (bwe),
		.waddr(fill_q[5:2]),
		.wdata({wacc_q, byte_val}),
		.raddr(braddr),
		.rdata(brdata)
	);

	assign craddr   = cnt_q[2:0];
	assign chain_rd = fresh_q ? shs_pkg::INIT_HASH[caddr_s1] : crdata;
	assign cwe      = (state_q == shs_pkg::ST_UPDATE) && (cnt_q != 6'd0);
	assign cwdata   = chain_rd + vreg_q[0];

	shs_ram #(
		.WIDTH(shs_pkg::WORD_W),
		.DEPTH(shs_pkg::CHAIN_WORDS)
	) u_chain_ram (
		.clk  (clk),
		.we   (cwe),
		.waddr(caddr_s1),
		.wdata(cwdata),
		.raddr(craddr),
		.rdata(crdata)
	);

	// Read a digest word only when the output slot is free by the time it lands.
	assign issue = (state_q == shs_pkg::ST_OUT) && !cnt_q[3] && !rdpend_s1
		&& (!oval_q || m_tready);

	always_comb begin
		if (cnt_q[5:4] == 2'b00) begin
			wt = brdata;
		end else begin
			wt = shs_pkg::small_sigma1(win_q[14]) + win_q[9]
				+ shs_pkg::small_sigma0(win_q[1]) + win_q[0];
		end
		t1 = vreg_q[7] + shs_pkg::big_sigma1(vreg_q[4])
			+ shs_pkg::choose(vreg_q[4], vreg_q[5], vreg_q[6])
			+ shs_pkg::ROUND_K[cnt_q] + wt;
		t2 = shs_pkg::big_sigma0(vreg_q[0]) + shs_pkg::major(vreg_q[0], vreg_q[1], vreg_q[2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= shs_pkg::ST_IDLE;
			cnt_q     <= '0;
			fill_q    <= '0;
			bits_q    <= '0;
			final_q   <= 1'b0;
			pad_q     <= 1'b0;
			marker_q  <= 1'b0;
			lenok_q   <= 1'b0;
			fresh_q   <= 1'b1;
			rdpend_s1 <= 1'b0;
			oval_q    <= 1'b0;
		end else begin
			rdpend_s1 <= issue;
			if (rdpend_s1) begin
				oval_q <= 1'b1;
			end else if (m_tready) begin
				oval_q <= 1'b0;
			end
			unique case (state_q)
				shs_pkg::ST_IDLE: begin
					if (accept) begin
						if (s_tuser && (fill_q == 6'd63)) begin
							fill_q  <= '0;
							bits_q  <= bits_q + 64'd512;
							final_q <= s_tlast;
							cnt_q   <= '0;
							state_q <= shs_pkg::ST_LOAD;
						end else begin
							if (s_tuser) begin
								fill_q <= fill_q + 6'd1;
							end
							if (s_tlast) begin
								pad_q   <= 1'b1;
								state_q <= shs_pkg::ST_PAD;
							end
						end
					end
				end
				shs_pkg::ST_PAD: begin
					marker_q <= 1'b1;
					if (!marker_q && (fill_q < 6'(shs_pkg::LEN_POS))) begin
						lenok_q <= 1'b1;
					end
					if (fill_q == 6'd63) begin
						fill_q  <= '0;
						cnt_q   <= '0;
						state_q <= shs_pkg::ST_LOAD;
					end else begin
						fill_q <= fill_q + 6'd1;
					end
				end
				shs_pkg::ST_LOAD: begin
					if (cnt_q == 6'(shs_pkg::CHAIN_WORDS)) begin
						cnt_q   <= '0;
						state_q <= shs_pkg::ST_ROUND;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				shs_pkg::ST_ROUND: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(shs_pkg::ROUNDS - 1)) begin
						state_q <= shs_pkg::ST_UPDATE;
					end
				end
				shs_pkg::ST_UPDATE: begin
					if (cnt_q == 6'(shs_pkg::CHAIN_WORDS)) begin
						cnt_q   <= '0;
						fresh_q <= 1'b0;
						if (pad_q) begin
							if (lenok_q) begin
								state_q <= shs_pkg::ST_OUT;
							end else begin
								lenok_q <= 1'b1;
								state_q <= shs_pkg::ST_PAD;
							end
						end else if (final_q) begin
							final_q <= 1'b0;
							pad_q   <= 1'b1;
							state_q <= shs_pkg::ST_PAD;
						end else begin
							state_q <= shs_pkg::ST_IDLE;
						end
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				shs_pkg::ST_OUT: begin
					if (issue) begin
						cnt_q <= cnt_q + 6'd1;
					end
					if (cnt_q[3] && !rdpend_s1) begin
						cnt_q    <= '0;
						fresh_q  <= 1'b1;
						bits_q   <= '0;
						pad_q    <= 1'b0;
						marker_q <= 1'b0;
						lenok_q  <= 1'b0;
						final_q  <= 1'b0;
						state_q  <= shs_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= shs_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		caddr_s1 <= craddr;
		if (byte_we) begin
			wacc_q <= {wacc_q[15:0], byte_val};
		end
		// Capture the message length before the marker byte lands.
		if ((state_q == shs_pkg::ST_PAD) && !marker_q) begin
			len_q <= bits_q + {55'b0, fill_q, 3'b000};
		end
		if (rdpend_s1) begin
			oword_q <= chain_rd;
			oidx_q  <= caddr_s1;
		end
		if (((state_q == shs_pkg::ST_LOAD) || (state_q == shs_pkg::ST_UPDATE))
			&& (cnt_q != 6'd0)) begin
			for (int k = 0; k < shs_pkg::CHAIN_WORDS - 1; k++) begin
				vreg_q[k] <= vreg_q[k+1];
			end
			vreg_q[shs_pkg::CHAIN_WORDS-1] <= chain_rd;
		end else if (state_q == shs_pkg::ST_ROUND) begin
			vreg_q[0] <= t1 + t2;
			vreg_q[1] <= vreg_q[0];
			vreg_q[2] <= vreg_q[1];
			vreg_q[3] <= vreg_q[2];
			vreg_q[4] <= vreg_q[3] + t1;
			vreg_q[5] <= vreg_q[4];
			vreg_q[6] <= vreg_q[5];
			vreg_q[7] <= vreg_q[6];
		end
		if (state_q == shs_pkg::ST_ROUND) begin
			for (int k = 0; k < shs_pkg::BLK_WORDS - 1; k++) begin
				win_q[k] <= win_q[k+1];
			end
			win_q[shs_pkg::BLK_WORDS-1] <= wt;
		end
	end

	assign m_tvalid = oval_q;
	assign m_tdata  = {5'b0, oidx_q, oword_q};
	assign m_tlast  = (oidx_q == 3'd7);

	a_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		rdpend_s1 |-> !oval_q)
		else $error("digest word landed on an occupied output slot");

	a_round_block_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == shs_pkg::ST_ROUND) |-> (fill_q == 6'd0))
		else $error("block fill nonzero during compression");

	a_round_end: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == shs_pkg::ST_ROUND) && (cnt_q == 6'(shs_pkg::ROUNDS - 1)))
		|=> (state_q == shs_pkg::ST_UPDATE))
		else $error("compression did not end after the last round");

	a_chain_rw: assert property (@(posedge clk) disable iff (!arst_n)
		cwe |-> (craddr != caddr_s1))
		else $error("chaining memory read and write at the same word");

	a_out_order: assert property (@(posedge clk) disable iff (!arst_n)
		rdpend_s1 |-> (caddr_s1 == 3'(cnt_q - 6'd1)))
		else $error("digest words out of order");

endmodule
